/* rtl/mnpc_pkg.sv */
// mnpc_pkg: character codes, policy constants and decode helpers for the
// mailbox name policy checker. No dependencies.
package mnpc_pkg;

    localparam int unsigned CFG_LEN_W = 10;
    localparam logic [CFG_LEN_W-1:0] MAX_LEN_RESET = 10'd490;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_R     = 8'h72;

    localparam logic [15:0] ASCII_MASK     = 16'hff80;
    localparam logic [15:0] SURR_MASK      = 16'hf800;
    localparam logic [15:0] SURR_VALUE     = 16'hd800;

    localparam logic [2:0] WORD_MATCHED = 3'd4;
    localparam logic [2:0] WORD_NO_MATCH = 3'd5;

    function automatic logic allowed_plain(input logic [7:0] c);
        logic ok;
        ok = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
             (c >= CH_0 && c <= CH_9) || c == CH_SPACE || c == CH_PLUS ||
             c == CH_COMMA || c == CH_DASH || c == CH_DOT || c == CH_COLON ||
             c == CH_EQ || c == CH_AT || c == CH_UNDER || c == CH_TILDE;
        return ok;
    endfunction

    // bit 6 set marks a non-base64 character
    function automatic logic [6:0] decode64(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd64;
        if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + 8'd26;
        end else if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0 + 8'd52;
        end else if (c == CH_PLUS) begin
            d = 8'd62;
        end else if (c == CH_COMMA) begin
            d = 8'd63;
        end
        return d[6:0];
    endfunction

    function automatic logic bad_unit(input logic [15:0] u);
        return ((u & ASCII_MASK) == 16'h0000) || ((u & SURR_MASK) == SURR_VALUE);
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_U;
            2'd1:    ch = CH_S;
            2'd2:    ch = CH_E;
            default: ch = CH_R;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/mailbox_name_policy_checker.sv */
// mailbox_name_policy_checker: streaming mailbox name validation with
// modified-UTF-7 run decoding. Depends on mnpc_pkg.
//
// Takes one name byte or end marker per clock while o_stall is low, with no
// gaps required. Every byte updates the registered per-name state; an end
// transfer loads the verdict into the output register, shown on o_valid the
// following cycle, and clears the state so the next name can start in that
// same cycle. Input stall rises only while a verdict is held by a stalled
// consumer. The max_name_length register is written through the cfg port,
// always ready, and resets to 490.
module mailbox_name_policy_checker
    import mnpc_pkg::*;
#(
    parameter int unsigned LENGTH_COUNT_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_name_byte,
    input  logic                 i_end_of_name,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_name_valid,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_LEN_W-1:0] i_cfg_max_name_length
);

    localparam int unsigned CMP_W =
        (LENGTH_COUNT_BITS > CFG_LEN_W) ? LENGTH_COUNT_BITS : CFG_LEN_W;

    logic [CFG_LEN_W-1:0]         r_max_len;
    logic [LENGTH_COUNT_BITS-1:0] r_count, n_count;
    logic                         r_rej, n_rej;
    logic                         r_in_run, n_in_run;
    logic [2:0]                   r_pos, n_pos;
    logic                         r_run_empty, n_run_empty;
    logic                         r_prev_adj, n_prev_adj;
    logic [15:0]                  r_partial, n_partial;
    logic [3:0]                   r_carry, n_carry;
    logic                         r_last_dot, n_last_dot;
    logic [2:0]                   r_word, n_word;
    logic                         r_out_valid;
    logic                         r_out_name_valid;

    logic       in_xfer;
    logic       verdict;
    logic [6:0] dec;
    logic [5:0] v;
    logic [15:0] unit;
    logic       unit_chk;

    assign o_stall     = r_out_valid & i_stall;
    assign in_xfer     = i_valid & ~o_stall;
    assign o_valid     = r_out_valid;
    assign o_name_valid = r_out_name_valid;
    assign o_cfg_ready = 1'b1;

    assign verdict = ~r_rej & ~r_in_run & (r_count != '0) & ~r_last_dot &
                     (r_word != WORD_MATCHED);
    assign dec = decode64(i_name_byte);
    assign v   = dec[6] ? 6'd0 : dec[5:0];

    always_comb begin
        n_count     = r_count;
        n_rej       = r_rej;
        n_in_run    = r_in_run;
        n_pos       = r_pos;
        n_run_empty = r_run_empty;
        n_prev_adj  = r_prev_adj;
        n_partial   = r_partial;
        n_carry     = r_carry;
        n_last_dot  = r_last_dot;
        n_word      = r_word;
        unit        = 16'h0000;
        unit_chk    = 1'b0;

        if (i_end_of_name) begin
            n_count     = '0;
            n_rej       = 1'b0;
            n_in_run    = 1'b0;
            n_pos       = 3'd0;
            n_run_empty = 1'b1;
            n_prev_adj  = 1'b0;
            n_partial   = 16'h0000;
            n_carry     = 4'h0;
            n_last_dot  = 1'b0;
            n_word      = 3'd0;
        end else begin
            if (CMP_W'(r_count) >= CMP_W'(r_max_len) || r_count == '1) begin
                n_rej = 1'b1;
            end
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end

            if (r_word < WORD_MATCHED && i_name_byte == word_char(r_word[1:0])) begin
                n_word = r_word + 3'd1;
            end else begin
                n_word = WORD_NO_MATCH;
            end

            if (r_count == '0 && (i_name_byte == CH_TILDE || i_name_byte == CH_DOT)) begin
                n_rej = 1'b1;
            end
            if (i_name_byte == CH_DOT && r_last_dot) begin
                n_rej = 1'b1;
            end
            n_last_dot = (i_name_byte == CH_DOT);

            if (r_in_run) begin
                if (i_name_byte == CH_DASH && (r_pos inside {3'd0, 3'd3, 3'd6})) begin
                    if (r_pos != 3'd0 && r_carry != 4'h0) begin
                        n_rej = 1'b1;
                    end
                    n_prev_adj = ~r_run_empty;
                    n_in_run   = 1'b0;
                    n_pos      = 3'd0;
                end else begin
                    if ((r_pos == 3'd0 && r_prev_adj) || dec[6]) begin
                        n_rej = 1'b1;
                    end
                    n_run_empty = 1'b0;
                    case (r_pos)
                        3'd0: n_partial = {v, 10'b0};
                        3'd1: n_partial = r_partial | {6'b0, v, 4'b0};
                        3'd2: begin
                            unit     = r_partial | {12'b0, v[5:2]};
                            unit_chk = 1'b1;
                            n_carry  = {2'b00, v[1:0]};
                        end
                        3'd3: n_partial = {r_carry[1:0], v, 8'b0};
                        3'd4: n_partial = r_partial | {8'b0, v, 2'b0};
                        3'd5: begin
                            unit     = r_partial | {14'b0, v[5:4]};
                            unit_chk = 1'b1;
                            n_carry  = v[3:0];
                        end
                        3'd6: n_partial = {r_carry, v, 6'b0};
                        default: begin
                            unit     = r_partial | {10'b0, v};
                            unit_chk = 1'b1;
                            n_carry  = 4'h0;
                        end
                    endcase
                    if (unit_chk && bad_unit(unit)) begin
                        n_rej = 1'b1;
                    end
                    n_pos = r_pos + 3'd1;
                end
            end else if (i_name_byte == CH_AMP) begin
                n_in_run    = 1'b1;
                n_pos       = 3'd0;
                n_run_empty = 1'b1;
                n_partial   = 16'h0000;
                n_carry     = 4'h0;
            end else begin
                if (!allowed_plain(i_name_byte)) begin
                    n_rej = 1'b1;
                end
                n_prev_adj = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_count     <= '0;
            r_rej       <= 1'b0;
            r_in_run    <= 1'b0;
            r_pos       <= 3'd0;
            r_run_empty <= 1'b1;
            r_prev_adj  <= 1'b0;
            r_partial   <= 16'h0000;
            r_carry     <= 4'h0;
            r_last_dot  <= 1'b0;
            r_word      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_max_name_length;
            end
            if (in_xfer) begin
                r_count     <= n_count;
                r_rej       <= n_rej;
                r_in_run    <= n_in_run;
                r_pos       <= n_pos;
                r_run_empty <= n_run_empty;
                r_prev_adj  <= n_prev_adj;
                r_partial   <= n_partial;
                r_carry     <= n_carry;
                r_last_dot  <= n_last_dot;
                r_word      <= n_word;
            end
            if (in_xfer && i_end_of_name) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_end_of_name) begin
            r_out_name_valid <= verdict;
        end
    end

endmodule

/* rtl/mnpc_port_checker.sv */
// mnpc_port_checker: port-level assertions for the mailbox name policy
// checker, bound to the top level. No package dependencies.
module mnpc_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_end_of_name,
    input logic o_valid,
    input logic i_stall,
    input logic o_name_valid
);

    logic in_xfer;
    assign in_xfer = i_valid & ~o_stall;

    a_held_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_name_valid))
        else $error("held verdict changed or dropped");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held verdict");

    a_byte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !i_end_of_name |=> !o_valid)
        else $error("byte transfer produced a verdict");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_end_of_name |=> o_valid)
        else $error("end transfer produced no verdict");

    a_empty_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_end_of_name ##1 in_xfer && i_end_of_name |=> !o_name_valid)
        else $error("empty name accepted");

endmodule

bind mailbox_name_policy_checker mnpc_port_checker u_mnpc_port_checker (.*);
